// ===== rtl/pac_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the polygon area and centroid block.
package pac_pkg;

	localparam int COORD_W = 16;
	localparam int OUT_W   = 24;
	localparam int FRAC_W  = 8;
	// Cross product of two vertices, sum of two coordinates, partial product.
	localparam int CROSS_W = 2 * COORD_W + 1;
	localparam int SUM_W   = COORD_W + 1;
	localparam int PART_W  = SUM_W + (CROSS_W - COORD_W);

	localparam logic signed [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

	typedef struct packed {
		logic signed [COORD_W-1:0] vertex_x;
		logic signed [COORD_W-1:0] vertex_y;
		logic                      last_vertex;
	} vertex_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] centroid_x;
		logic signed [OUT_W-1:0] centroid_y;
		logic                    used_mean;
		logic                    too_many;
	} result_t;

	typedef enum logic [3:0] {
		S_COLLECT,
		S_CLOSE,
		S_DRAIN,
		S_PREP,
		S_LOAD_X,
		S_RUN_X,
		S_LOAD_Y,
		S_RUN_Y,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic vtx_take;
		logic close_edge;
		logic prep;
		logic div_start;
		logic sel_y;
		logic out_load;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic overflow;
		logic div_done;
	} status_t;

endpackage

// ===== rtl/pac_divider.sv =====
`timescale 1ns / 1ps
// Restoring divider giving a signed, saturated Q8 quotient, one bit per cycle.
module pac_divider #(
	parameter int NUM_W = 60,
	parameter int DEN_W = 46
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [NUM_W-1:0]          num,
	input  logic signed [DEN_W-1:0]          den,
	output logic                             done,
	output logic signed [pac_pkg::OUT_W-1:0] quo
);
	import pac_pkg::*;

	localparam int QW    = NUM_W + FRAC_W;
	localparam int CNT_W = $clog2(QW);

	logic [QW-1:0]    quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] dvs_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [NUM_W-1:0] num_mag;
	logic [DEN_W-1:0] den_mag;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W+1:0] diff;
	logic             fits;
	logic             big;
	logic [OUT_W-1:0] low;

	assign num_mag = num[NUM_W-1] ? (~num + 1'b1) : num;
	assign den_mag = den[DEN_W-1] ? (~den + 1'b1) : den;
	assign rem_sh  = {rem_q[DEN_W-1:0], quo_q[QW-1]};
	assign diff    = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign fits    = !diff[DEN_W+1];

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= {num_mag, {FRAC_W{1'b0}}};
			rem_q <= '0;
			dvs_q <= den_mag;
			neg_q <= num[NUM_W-1] ^ den[DEN_W-1];
		end else if (run_q) begin
			quo_q <= {quo_q[QW-2:0], fits};
			rem_q <= fits ? diff[DEN_W:0] : rem_sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(QW - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Any quotient bit at or above the sign position of the output saturates.
	assign big  = |quo_q[QW-1:OUT_W-1];
	assign low  = quo_q[OUT_W-1:0];
	assign done = done_q;

	always_comb begin
		if (neg_q) begin
			quo = big ? SAT_NEG : $signed(~low + 1'b1);
		end else begin
			quo = big ? SAT_POS : $signed(low);
		end
	end

endmodule

// ===== rtl/pac_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: edge pipeline, shoelace accumulators, divider operands and result register.
module pac_datapath #(
	parameter int MAX_VERTICES = 1024,
	parameter int CNT_W        = 11,
	parameter int AS_W         = 44,
	parameter int WS_W         = 60,
	parameter int PS_W         = 27,
	parameter int DEN_W        = 46
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pac_pkg::cmd_t     cmd,
	input  pac_pkg::vertex_t  vertex,
	output pac_pkg::status_t  status,
	output pac_pkg::result_t  result
);
	import pac_pkg::*;

	localparam int MIN_POLY = 3;

	logic signed [COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [CNT_W-1:0]          count_q;
	logic                      ovf_q;
	logic signed [AS_W-1:0]    area_q;
	logic signed [WS_W-1:0]    wx_q, wy_q;
	logic signed [PS_W-1:0]    px_q, py_q;

	logic                      room;
	logic                      edge_go;
	logic signed [COORD_W-1:0] ex_j, ey_j;

	logic                      v_s1, v_s2, v_s3;
	logic signed [2*COORD_W-1:0] p0_s1, p1_s1;
	logic signed [SUM_W-1:0]   sx_s1, sy_s1, sx_s2, sy_s2;
	logic signed [CROSS_W-1:0] c_s2, c_s3;
	logic signed [PART_W-1:0]  pxl_s3, pxh_s3, pyl_s3, pyh_s3;

	logic signed [AS_W-1:0]    area_term;
	logic signed [WS_W-1:0]    wx_term, wy_term;

	logic signed [DEN_W-1:0]   den_q;
	logic                      mean_q;
	logic signed [OUT_W-1:0]   res_x_q, res_y_q;
	result_t                   result_q;

	logic signed [WS_W-1:0]    div_num;
	logic signed [DEN_W-1:0]   div_den;
	logic signed [OUT_W-1:0]   div_quo;
	logic                      div_done;

	assign room    = count_q < CNT_W'(MAX_VERTICES);
	assign edge_go = (cmd.vtx_take && room && (count_q != '0)) || cmd.close_edge;
	assign ex_j    = cmd.close_edge ? first_x_q : vertex.vertex_x;
	assign ey_j    = cmd.close_edge ? first_y_q : vertex.vertex_y;

	// Edge pipeline: products, cross product, then weighted partial products.
	always_ff @(posedge clk) begin
		p0_s1  <= prev_x_q * ey_j;
		p1_s1  <= ex_j * prev_y_q;
		sx_s1  <= {prev_x_q[COORD_W-1], prev_x_q} + {ex_j[COORD_W-1], ex_j};
		sy_s1  <= {prev_y_q[COORD_W-1], prev_y_q} + {ey_j[COORD_W-1], ey_j};
		c_s2   <= {p0_s1[2*COORD_W-1], p0_s1} - {p1_s1[2*COORD_W-1], p1_s1};
		sx_s2  <= sx_s1;
		sy_s2  <= sy_s1;
		pxl_s3 <= sx_s2 * $signed({1'b0, c_s2[COORD_W-1:0]});
		pxh_s3 <= sx_s2 * $signed(c_s2[CROSS_W-1:COORD_W]);
		pyl_s3 <= sy_s2 * $signed({1'b0, c_s2[COORD_W-1:0]});
		pyh_s3 <= sy_s2 * $signed(c_s2[CROSS_W-1:COORD_W]);
		c_s3   <= c_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= edge_go;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign area_term = {{(AS_W-CROSS_W){c_s3[CROSS_W-1]}}, c_s3};
	assign wx_term   = ({{(WS_W-PART_W){pxh_s3[PART_W-1]}}, pxh_s3} <<< COORD_W)
		+ {{(WS_W-PART_W){pxl_s3[PART_W-1]}}, pxl_s3};
	assign wy_term   = ({{(WS_W-PART_W){pyh_s3[PART_W-1]}}, pyh_s3} <<< COORD_W)
		+ {{(WS_W-PART_W){pyl_s3[PART_W-1]}}, pyl_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			area_q    <= '0;
			wx_q      <= '0;
			wy_q      <= '0;
			px_q      <= '0;
			py_q      <= '0;
		end else if (cmd.clear) begin
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			area_q    <= '0;
			wx_q      <= '0;
			wy_q      <= '0;
			px_q      <= '0;
			py_q      <= '0;
		end else begin
			if (cmd.vtx_take) begin
				if (room) begin
					if (count_q == '0) begin
						first_x_q <= vertex.vertex_x;
						first_y_q <= vertex.vertex_y;
					end
					prev_x_q <= vertex.vertex_x;
					prev_y_q <= vertex.vertex_y;
					count_q  <= count_q + 1'b1;
					px_q     <= px_q + {{(PS_W-COORD_W){vertex.vertex_x[COORD_W-1]}},
						vertex.vertex_x};
					py_q     <= py_q + {{(PS_W-COORD_W){vertex.vertex_y[COORD_W-1]}},
						vertex.vertex_y};
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (v_s3) begin
				area_q <= area_q + area_term;
				wx_q   <= wx_q + wx_term;
				wy_q   <= wy_q + wy_term;
			end
		end
	end

	// Divisor for the area case is three times the doubled area.
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			den_q  <= {{2{area_q[AS_W-1]}}, area_q} + {area_q[AS_W-1], area_q, 1'b0};
			mean_q <= (count_q < CNT_W'(MIN_POLY)) || (area_q == '0);
		end
	end

	always_comb begin
		if (mean_q) begin
			div_num = cmd.sel_y ? {{(WS_W-PS_W){py_q[PS_W-1]}}, py_q}
				: {{(WS_W-PS_W){px_q[PS_W-1]}}, px_q};
			div_den = $signed(DEN_W'(count_q));
		end else begin
			div_num = cmd.sel_y ? wy_q : wx_q;
			div_den = den_q;
		end
	end

	pac_divider #(
		.NUM_W (WS_W),
		.DEN_W (DEN_W)
	) u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (div_done) begin
			if (cmd.sel_y) begin
				res_y_q <= div_quo;
			end else begin
				res_x_q <= div_quo;
			end
		end
		if (cmd.out_load) begin
			if (ovf_q) begin
				result_q.centroid_x <= '0;
				result_q.centroid_y <= '0;
				result_q.used_mean  <= 1'b0;
				result_q.too_many   <= 1'b1;
			end else begin
				result_q.centroid_x <= res_x_q;
				result_q.centroid_y <= res_y_q;
				result_q.used_mean  <= mean_q;
				result_q.too_many   <= 1'b0;
			end
		end
	end

	assign status.busy     = v_s1 | v_s2 | v_s3;
	assign status.overflow = ovf_q;
	assign status.div_done = div_done;
	assign result          = result_q;

endmodule

// ===== rtl/pac_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine sequencing vertex intake, drain, both divides and the result.
module pac_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vertex_valid,
	input  logic              last_vertex,
	input  logic              result_stall,
	input  pac_pkg::status_t  status,
	output pac_pkg::cmd_t     cmd,
	output logic              vertex_stall,
	output logic              result_valid
);
	import pac_pkg::*;

	state_t state_q, state_d;
	logic   result_valid_q;
	logic   accept;
	logic   can_load;

	assign accept   = vertex_valid && (state_q == S_COLLECT);
	assign can_load = !result_valid_q || !result_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_COLLECT: if (accept && last_vertex) state_d = S_CLOSE;
			S_CLOSE:   state_d = S_DRAIN;
			S_DRAIN:   if (!status.busy) state_d = S_PREP;
			S_PREP:    state_d = status.overflow ? S_FINISH : S_LOAD_X;
			S_LOAD_X:  state_d = S_RUN_X;
			S_RUN_X:   if (status.div_done) state_d = S_LOAD_Y;
			S_LOAD_Y:  state_d = S_RUN_Y;
			S_RUN_Y:   if (status.div_done) state_d = S_FINISH;
			S_FINISH:  if (can_load) state_d = S_COLLECT;
			default:   state_d = S_COLLECT;
		endcase
	end

	always_comb begin
		cmd          = '0;
		vertex_stall = 1'b1;
		unique case (state_q)
			S_COLLECT: begin
				vertex_stall = 1'b0;
				cmd.vtx_take = accept;
			end
			S_CLOSE:  cmd.close_edge = !status.overflow;
			S_DRAIN:  ;
			S_PREP:   cmd.prep = 1'b1;
			S_LOAD_X: cmd.div_start = 1'b1;
			S_RUN_X:  ;
			S_LOAD_Y: begin
				cmd.sel_y     = 1'b1;
				cmd.div_start = 1'b1;
			end
			S_RUN_Y:  cmd.sel_y = 1'b1;
			S_FINISH: begin
				cmd.out_load = can_load;
				cmd.clear    = can_load;
			end
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_COLLECT;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;

endmodule

// ===== rtl/polygon_area_centroid.sv =====
`timescale 1ns / 1ps
// Top level of the streaming polygon area and centroid block.
//
//   Channel  | Handshake                    | Payload
//   ---------+------------------------------+-----------------------------------------
//   vertex   | vertex_valid / vertex_stall  | vertex_x, vertex_y, last_vertex
//   result   | result_valid / result_stall  | centroid_x, centroid_y, used_mean, too_many
//
// Vertices are taken back to back; each edge runs down a three-stage multiply pipeline.
// After the last vertex the block closes the polygon, drains the pipeline, then runs the
// one-bit-a-cycle divider twice over WS_W + 8 bits, once per coordinate, unless the vertex
// limit was exceeded; vertex_stall stays high until the result is loaded.
// Reset clears all accumulators; no clearing pass is needed afterwards.
// A finished result waits in its output register, so a stalled result does not block the
// next polygon's vertices; only the following result waits for that register to empty.
module polygon_area_centroid #(
	parameter int MAX_VERTICES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vertex_valid,
	output logic              vertex_stall,
	input  pac_pkg::vertex_t  vertex,
	output logic              result_valid,
	input  logic              result_stall,
	output pac_pkg::result_t  result
);
	import pac_pkg::*;

	// The vertex count must hold the limit itself; the sums grow with the edge count.
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int AS_W  = CROSS_W + CNT_W;
	localparam int WS_W  = 3 * COORD_W + 1 + CNT_W;
	localparam int PS_W  = COORD_W + CNT_W;
	localparam int DEN_W = AS_W + 2;

	cmd_t    cmd;
	status_t status;

	// The controller decides when a vertex transfer happens and what the datapath does.
	pac_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_valid (vertex_valid),
		.last_vertex  (vertex.last_vertex),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd),
		.vertex_stall (vertex_stall),
		.result_valid (result_valid)
	);

	// The datapath holds the polygon state, the edge pipeline, the divider and the result.
	pac_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.CNT_W        (CNT_W),
		.AS_W         (AS_W),
		.WS_W         (WS_W),
		.PS_W         (PS_W),
		.DEN_W        (DEN_W)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.vertex (vertex),
		.status (status),
		.result (result)
	);

`ifndef NO_ASSERTIONS
	// Clearing the accumulators while an edge is still in flight would leak it into the
	// next polygon.
	a_clear_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !status.busy)
		else $error("polygon state cleared with edges still in the pipeline");

	// A result only appears after the controller loads the output register.
	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(cmd.out_load))
		else $error("result valid rose without an output load");

	// An overflowed polygon reports zero coordinates and no mean fallback.
	a_overflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.too_many) |->
			(result.centroid_x == '0 && result.centroid_y == '0 && !result.used_mean))
		else $error("overflowed result carries coordinates");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the streaming polygon area and centroid block.
module tb;
	import pac_pkg::*;

	localparam int     MAX_VERTS    = 1024;
	localparam int     PHASE_VERTS  = 200;
	localparam int     DRAIN_LIMIT  = 200000;
	localparam int     TAIL_CYCLES  = 300;
	localparam longint CENTROID_MAX = 8388607;
	localparam longint CENTROID_MIN = -8388608;

	// How widely the coordinates of a random polygon are spread.
	typedef enum {SPREAD_FULL, SPREAD_NEAR, SPREAD_EDGE} spread_t;
	// Outline of a random polygon.
	typedef enum {SHAPE_TINY, SHAPE_LINE, SHAPE_CLOSED, SHAPE_PLAIN} shape_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    vertex_valid = 1'b0;
	logic    vertex_stall;
	vertex_t vertex = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// Vertices waiting to be offered, and centroids predicted but not yet seen.
	vertex_t vertex_backlog[$];
	result_t centroid_due[$];

	int sender_idle_pct = 24;
	int receiver_idle_pct = 76;
	int phase_vertices;
	int polygons_queued;
	int vertices_sent;
	int results_checked;
	int mean_results;
	int saturated_results;
	int overflow_results;
	int mismatches;

	// Running state of the polygon being accumulated, as the block should hold it.
	longint      first_x, first_y, prev_x, prev_y;
	longint      twice_area, moment_x, moment_y, coord_sum_x, coord_sum_y;
	int unsigned vertices_held;
	bit          vertex_limit_hit;

	polygon_area_centroid #(
		.MAX_VERTICES(MAX_VERTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.vertex_valid(vertex_valid),
		.vertex_stall(vertex_stall),
		.vertex(vertex),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void clear_polygon();
		first_x = 0;
		first_y = 0;
		prev_x = 0;
		prev_y = 0;
		twice_area = 0;
		moment_x = 0;
		moment_y = 0;
		coord_sum_x = 0;
		coord_sum_y = 0;
		vertices_held = 0;
		vertex_limit_hit = 1'b0;
	endfunction

	// One shoelace edge: its cross product feeds the doubled area, and the same product
	// weighted by the coordinate sums feeds the first moments.
	function automatic void add_shoelace_edge(longint xi, longint yi, longint xj, longint yj);
		longint cp;
		cp = xi * yj - xj * yi;
		twice_area += cp;
		moment_x += (xi + xj) * cp;
		moment_y += (yi + yj) * cp;
	endfunction

	// Signed quotient num / den in Q8, truncated toward zero and clamped to 24 bits.
	// The integer part is capped first, which keeps the fraction term in range.
	function automatic logic signed [OUT_W-1:0] q8_quotient(longint num, longint den);
		bit              neg;
		longint unsigned un, ud, q, r, mag;
		longint          val;
		neg = (num < 0) != (den < 0);
		un = (num < 0) ? -num : num;
		ud = (den < 0) ? -den : den;
		q = un / ud;
		r = un % ud;
		if (q > 64'd65536)
			q = 64'd65536;
		mag = q * 256 + (r * 256) / ud;
		val = neg ? -longint'(mag) : longint'(mag);
		if (val > CENTROID_MAX)
			val = CENTROID_MAX;
		if (val < CENTROID_MIN)
			val = CENTROID_MIN;
		return val[OUT_W-1:0];
	endfunction

	// Folds one accepted vertex into the running polygon. Returns 1 with the expected
	// centroid when the vertex closes the polygon.
	function automatic bit fold_vertex(vertex_t v, output result_t centroid);
		longint x, y;
		x = $signed(v.vertex_x);
		y = $signed(v.vertex_y);
		centroid = '0;
		if (vertices_held < MAX_VERTS) begin
			if (vertices_held == 0) begin
				first_x = x;
				first_y = y;
			end else begin
				add_shoelace_edge(prev_x, prev_y, x, y);
			end
			coord_sum_x += x;
			coord_sum_y += y;
			vertices_held++;
			prev_x = x;
			prev_y = y;
		end else begin
			vertex_limit_hit = 1'b1;
		end
		if (!v.last_vertex)
			return 1'b0;
		if (vertex_limit_hit) begin
			centroid.too_many = 1'b1;
		end else begin
			add_shoelace_edge(prev_x, prev_y, first_x, first_y);
			if (vertices_held < 3 || twice_area == 0) begin
				centroid.used_mean = 1'b1;
				centroid.centroid_x = q8_quotient(coord_sum_x, longint'(vertices_held));
				centroid.centroid_y = q8_quotient(coord_sum_y, longint'(vertices_held));
			end else begin
				centroid.centroid_x = q8_quotient(moment_x, 3 * twice_area);
				centroid.centroid_y = q8_quotient(moment_y, 3 * twice_area);
			end
		end
		clear_polygon();
		return 1'b1;
	endfunction

	// Sender. A vertex stays on the bus until its transfer; a gap is only ever
	// inserted between transfers, never by withdrawing an offered vertex.
	always @(posedge clk) begin : drive_vertices
		bit      taken;
		result_t predicted;
		if (arst_n) begin
			taken = vertex_valid && !vertex_stall;
			if (taken) begin
				if (fold_vertex(vertex, predicted))
					centroid_due = {centroid_due, predicted};
				vertices_sent++;
			end
			if (taken || !vertex_valid) begin
				if (vertex_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					vertex <= vertex_backlog.pop_front();
					vertex_valid <= 1'b1;
				end else if (taken) begin
					vertex_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver. Every result transfer is checked field by field against the oldest
	// predicted centroid; the stall is redrawn on every cycle.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (centroid_due.size() == 0) begin
					$error("result transfer with no centroid pending");
					mismatches++;
				end else begin
					want = centroid_due.pop_front();
					results_checked++;
					if (result.centroid_x !== want.centroid_x) begin
						$error("centroid_x expected %0d got %0d", want.centroid_x,
							result.centroid_x);
						mismatches++;
					end
					if (result.centroid_y !== want.centroid_y) begin
						$error("centroid_y expected %0d got %0d", want.centroid_y,
							result.centroid_y);
						mismatches++;
					end
					if (result.used_mean !== want.used_mean) begin
						$error("used_mean expected %0d got %0d", want.used_mean,
							result.used_mean);
						mismatches++;
					end
					if (result.too_many !== want.too_many) begin
						$error("too_many expected %0d got %0d", want.too_many,
							result.too_many);
						mismatches++;
					end
					if (want.used_mean)
						mean_results++;
					if (want.too_many)
						overflow_results++;
					if (!want.used_mean && (want.centroid_x == SAT_POS
							|| want.centroid_x == SAT_NEG))
						saturated_results++;
				end
			end
			result_stall <= ($urandom_range(99) < receiver_idle_pct);
		end
	end

	task automatic queue_vertex(int x, int y, bit closing);
		vertex_t v;
		v.vertex_x = x[COORD_W-1:0];
		v.vertex_y = y[COORD_W-1:0];
		v.last_vertex = closing;
		vertex_backlog = {vertex_backlog, v};
		phase_vertices++;
		if (closing)
			polygons_queued++;
	endtask

	function automatic int pick_coord(spread_t spread);
		case (spread)
			SPREAD_FULL: return int'($urandom_range(65535)) - 32768;
			SPREAD_NEAR: return int'($urandom_range(200)) - 100;
			default: begin
				case ($urandom_range(5))
					0: return -32768;
					1: return 32767;
					2: return 0;
					3: return -1;
					4: return 1;
					default: return -32767;
				endcase
			end
		endcase
	endfunction

	// Random polygon: mostly ordinary outlines, with a share of one- and two-vertex
	// polygons, collinear runs that enclose no area, and outlines closed explicitly
	// by repeating the first vertex.
	task automatic queue_random_polygon();
		int      roll, n, x0, y0, dx, dy;
		shape_t  shape;
		spread_t spread;
		roll = $urandom_range(99);
		if (roll < 10)
			shape = SHAPE_TINY;
		else if (roll < 20)
			shape = SHAPE_LINE;
		else if (roll < 30)
			shape = SHAPE_CLOSED;
		else
			shape = SHAPE_PLAIN;
		roll = $urandom_range(99);
		if (roll < 40)
			spread = SPREAD_FULL;
		else if (roll < 80)
			spread = SPREAD_NEAR;
		else
			spread = SPREAD_EDGE;
		case (shape)
			SHAPE_TINY: n = $urandom_range(2, 1);
			SHAPE_LINE: n = $urandom_range(8, 3);
			default:    n = $urandom_range(12, 3);
		endcase
		if (shape == SHAPE_LINE) begin
			x0 = int'($urandom_range(2000)) - 1000;
			y0 = int'($urandom_range(2000)) - 1000;
			dx = int'($urandom_range(100)) - 50;
			dy = int'($urandom_range(100)) - 50;
			for (int k = 0; k < n; k++)
				queue_vertex(x0 + k * dx, y0 + k * dy, k == n - 1);
		end else begin
			x0 = pick_coord(spread);
			y0 = pick_coord(spread);
			queue_vertex(x0, y0, n == 1 && shape != SHAPE_CLOSED);
			for (int k = 1; k < n; k++)
				queue_vertex(pick_coord(spread), pick_coord(spread),
					k == n - 1 && shape != SHAPE_CLOSED);
			if (shape == SHAPE_CLOSED)
				queue_vertex(x0, y0, 1'b1);
		end
	endtask

	// Waits until every queued vertex has gone and every predicted
	// centroid has arrived, so that the block is idle when the pattern changes.
	task automatic settle();
		int waited;
		waited = 0;
		while ((vertex_backlog.size() != 0 || vertex_valid || centroid_due.size() != 0)
				&& waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
	endtask

	initial begin
		clear_polygon();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed polygons first. A lone vertex and a pair that start at the coordinate
		// extremes fall back to the mean, as does a collinear triangle. A triangle
		// spanning the whole grid, a square closed by repeating its first vertex, and
		// two nearly cancelling bow-ties, whose centroids lie far off the grid and
		// clamp to either end of the output range, complete the set.
		queue_vertex(32767, -32768, 1'b1);
		queue_vertex(-32768, 32767, 1'b0);
		queue_vertex(-1, -1, 1'b1);
		queue_vertex(-32768, -32768, 1'b0);
		queue_vertex(32767, -32768, 1'b0);
		queue_vertex(32767, 32767, 1'b1);
		queue_vertex(1, 1, 1'b0);
		queue_vertex(2, 2, 1'b0);
		queue_vertex(3, 3, 1'b1);
		queue_vertex(0, 0, 1'b0);
		queue_vertex(4, 0, 1'b0);
		queue_vertex(4, 4, 1'b0);
		queue_vertex(0, 4, 1'b0);
		queue_vertex(0, 0, 1'b1);
		queue_vertex(-32000, 1000, 1'b0);
		queue_vertex(32000, -1000, 1'b0);
		queue_vertex(32000, 1001, 1'b0);
		queue_vertex(-32000, -1000, 1'b1);
		queue_vertex(32000, 1000, 1'b0);
		queue_vertex(-32000, -1000, 1'b0);
		queue_vertex(-32000, 1001, 1'b0);
		queue_vertex(32000, -1000, 1'b1);

		// First random phase: the sender seldom idles, the receiver mostly stalls.
		phase_vertices = 0;
		while (phase_vertices < PHASE_VERTS)
			queue_random_polygon();
		settle();

		// Second phase: the other way round.
		sender_idle_pct = 76;
		receiver_idle_pct = 24;
		phase_vertices = 0;
		while (phase_vertices < PHASE_VERTS)
			queue_random_polygon();
		settle();

		// Last phase at full rate on both sides.
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		phase_vertices = 0;
		while (phase_vertices < PHASE_VERTS)
			queue_random_polygon();
		settle();

		repeat (TAIL_CYCLES) @(negedge clk);
		if (centroid_due.size() != 0) begin
			$error("%0d predicted centroids never arrived", centroid_due.size());
			mismatches += centroid_due.size();
		end

		$display("Streamed %0d vertices in %0d polygons; %0d centroids compared.",
			vertices_sent, polygons_queued, results_checked);
		$display("Mean fallbacks %0d, clamped centroids %0d, over the vertex limit %0d.",
			mean_results, saturated_results, overflow_results);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/pac_pkg.sv
rtl/pac_divider.sv
rtl/pac_datapath.sv
rtl/pac_ctrl.sv
rtl/polygon_area_centroid.sv
tb/sv/tb.sv
